// File: hdl/ksha_pkg.sv
// Shared types, constants and hash helpers for the k-mer soft hash accumulator.
`default_nettype none

package ksha_pkg;

  localparam int LEN_W     = 6;
  localparam int LANE_W    = 6;
  localparam int SUM_W     = 32;
  localparam int CFG_IDX_W = 4;
  localparam int SALT_N    = 32;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 4'd1;

  localparam logic [LEN_W-1:0] MIN_LEN_RST = 6'd1;
  localparam logic [LEN_W-1:0] MAX_LEN_RST = 6'd32;

  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_T = 8'h54;

  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_C = 2'd1;
  localparam logic [1:0] CODE_G = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  localparam logic [63:0] FMIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;
  localparam int          FMIX_SH = 33;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 32'sh7fffffff;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 32'sh80000000;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [LANE_W-1:0]       lane;
    logic signed [SUM_W-1:0] sum_value;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic clear_window;
    logic add_base;
    logic clear_sums;
    logic load_k;
    logic issue;
    logic rd_shift;
  } ksha_cmd_t;

  typedef struct packed {
    logic hash_empty;
    logic k_at_hi;
    logic pipe_idle;
    logic lane_last;
  } ksha_status_t;

  typedef logic [SALT_N-1:0][63:0] salt_tab_t;

  function automatic logic [1:0] base_code(input logic [7:0] sym);
    logic [1:0] code;
    case (sym)
      CHAR_C:  code = CODE_C;
      CHAR_G:  code = CODE_G;
      CHAR_T:  code = CODE_T;
      default: code = CODE_A;
    endcase
    return code;
  endfunction

  function automatic logic [63:0] fmix64(input logic [63:0] x);
    logic [63:0] h;
    h = x ^ (x >> FMIX_SH);
    h = h * FMIX_C1;
    h = h ^ (h >> FMIX_SH);
    h = h * FMIX_C2;
    h = h ^ (h >> FMIX_SH);
    return h;
  endfunction

  function automatic salt_tab_t build_salts();
    salt_tab_t t;
    for (int i = 0; i < SALT_N; i++) begin
      t[i] = fmix64(64'(i + 2));
    end
    return t;
  endfunction

  localparam salt_tab_t SALT_TABLE = build_salts();

endpackage

`default_nettype wire

// File: hdl/ksha_datapath.sv
// Datapath: base window, length bounds, pipelined fmix64 unit, vote sums and readout.
`default_nettype none

module ksha_datapath
  import ksha_pkg::*;
#(
  parameter int DIM      = 64,
  parameter int MAX_KMER = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire in_item_t             in_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LEN_W-1:0]     cfg_data,
  input  wire ksha_cmd_t            cmd,
  output ksha_status_t              status,
  output out_item_t                 out_data
);

  localparam int WIN_W  = 2 * MAX_KMER;
  localparam int SEEN_W = $clog2(MAX_KMER + 1);

  logic [LEN_W-1:0]  min_len_r;
  logic [LEN_W-1:0]  max_len_r;
  logic [WIN_W-1:0]  win_r;
  logic [WIN_W-1:0]  win_nxt;
  logic [SEEN_W-1:0] seen_r;
  logic [SEEN_W-1:0] seen_nxt;
  logic [LEN_W-1:0]  k_r;
  logic [LEN_W-1:0]  k_nxt;
  logic [LEN_W-1:0]  lo;
  logic [LEN_W-1:0]  hi;
  logic [LEN_W-1:0]  cap;
  logic [6:0]        sh;
  logic [63:0]       kmer;

  logic [63:0] x0_r;
  logic [63:0] x1;
  logic [63:0] m1_ll;
  logic [31:0] m1_hl, m1_lh;
  logic [63:0] pp1_ll_r;
  logic [31:0] pp1_hl_r, pp1_lh_r;
  logic [63:0] prod1;
  logic [63:0] x2_r;
  logic [63:0] m2_ll;
  logic [31:0] m2_hl, m2_lh;
  logic [63:0] pp2_ll_r;
  logic [31:0] pp2_hl_r, pp2_lh_r;
  logic [63:0] prod2;
  logic [63:0] hash_r;
  logic [4:0]  v_r;

  logic signed [SUM_W-1:0] sums_r [DIM];
  logic [LANE_W-1:0]       lane_r;
  logic                    lane_last;

  always_comb begin
    win_nxt  = (WIN_W'(base_code(in_data.symbol)) << (WIN_W - 2)) | (win_r >> 2);
    seen_nxt = (seen_r == SEEN_W'(MAX_KMER)) ? seen_r : seen_r + 1'b1;
    lo       = (min_len_r == '0) ? LEN_W'(1) : min_len_r;
    cap      = (max_len_r > LEN_W'(MAX_KMER)) ? LEN_W'(MAX_KMER) : max_len_r;
    hi       = (cap > LEN_W'(seen_r)) ? LEN_W'(seen_r) : cap;
    k_nxt    = cmd.load_k ? lo : k_r + 1'b1;
    sh       = 7'(WIN_W) - 7'({k_r, 1'b0});
    kmer     = 64'(win_r >> sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RST;
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MIN_LEN) min_len_r <= cfg_data;
      if (cfg_index == CFG_MAX_LEN) max_len_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      seen_r <= '0;
      k_r    <= '0;
    end else begin
      if (cmd.clear_window) begin
        win_r  <= '0;
        seen_r <= '0;
      end else if (cmd.add_base) begin
        win_r  <= win_nxt;
        seen_r <= seen_nxt;
      end
      if (cmd.load_k || cmd.issue) k_r <= k_nxt;
    end
  end

  always_comb begin
    x1    = x0_r ^ (x0_r >> FMIX_SH);
    m1_ll = x1[31:0] * FMIX_C1[31:0];
    m1_hl = x1[63:32] * FMIX_C1[31:0];
    m1_lh = x1[31:0] * FMIX_C1[63:32];
    prod1 = pp1_ll_r + {pp1_hl_r + pp1_lh_r, 32'h0};
    m2_ll = x2_r[31:0] * FMIX_C2[31:0];
    m2_hl = x2_r[63:32] * FMIX_C2[31:0];
    m2_lh = x2_r[31:0] * FMIX_C2[63:32];
    prod2 = pp2_ll_r + {pp2_hl_r + pp2_lh_r, 32'h0};
  end

  always_ff @(posedge clk) begin
    x0_r     <= SALT_TABLE[5'(k_r - 1'b1)] ^ kmer;
    pp1_ll_r <= m1_ll;
    pp1_hl_r <= m1_hl;
    pp1_lh_r <= m1_lh;
    x2_r     <= prod1 ^ (prod1 >> FMIX_SH);
    pp2_ll_r <= m2_ll;
    pp2_hl_r <= m2_hl;
    pp2_lh_r <= m2_lh;
    hash_r   <= prod2 ^ (prod2 >> FMIX_SH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], cmd.issue};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < DIM; j++) sums_r[j] <= '0;
    end else if (cmd.clear_sums) begin
      for (int j = 0; j < DIM; j++) sums_r[j] <= '0;
    end else if (cmd.rd_shift) begin
      for (int j = 0; j < DIM - 1; j++) sums_r[j] <= sums_r[j + 1];
      sums_r[DIM - 1] <= sums_r[0];
    end else if (v_r[4]) begin
      for (int j = 0; j < DIM; j++) begin
        if (hash_r[j]) begin
          if (sums_r[j] != SUM_MAX) sums_r[j] <= sums_r[j] + 32'sd1;
        end else begin
          if (sums_r[j] != SUM_MIN) sums_r[j] <= sums_r[j] - 32'sd1;
        end
      end
    end
  end

  assign lane_last = (lane_r == LANE_W'(DIM - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r <= '0;
    end else if (cmd.rd_shift) begin
      lane_r <= lane_last ? '0 : lane_r + 1'b1;
    end
  end

  always_comb begin
    status.hash_empty  = (lo > hi);
    status.k_at_hi     = (k_r == hi);
    status.pipe_idle   = (v_r == '0);
    status.lane_last   = lane_last;
    out_data.lane      = lane_r;
    out_data.sum_value = sums_r[0];
    out_data.last      = lane_last;
  end

  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_sums |-> (v_r == '0))
    else $error("sums cleared with hashes in flight");

  a_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_shift |-> (v_r == '0))
    else $error("readout overlaps a vote");

  a_issue_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue && status.k_at_hi) |=> !cmd.issue)
    else $error("k-mer issued past the upper length");

endmodule

`default_nettype wire

// File: hdl/ksha_ctrl.sv
// Controller state machine: decodes ops, sequences k-mer issue, drain and readout.
`default_nettype none

module ksha_ctrl
  import ksha_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire in_item_t     in_data,
  output logic              in_stall,
  output logic              out_valid,
  input  wire logic         out_stall,
  input  wire ksha_status_t status,
  output ksha_cmd_t         cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       in_take;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_READ);
  assign in_take   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          case (in_data.op)
            OP_START: cmd.clear_window = 1'b1;
            OP_ADD: begin
              cmd.add_base = 1'b1;
              state_nxt    = ST_SETUP;
            end
            OP_CLEAR: cmd.clear_sums = 1'b1;
            OP_READ:  state_nxt = ST_READ;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SETUP: begin
        if (status.hash_empty) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.load_k = 1'b1;
          state_nxt  = ST_HASH;
        end
      end
      ST_HASH: begin
        cmd.issue = 1'b1;
        if (status.k_at_hi) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (status.pipe_idle) state_nxt = ST_IDLE;
      end
      ST_READ: begin
        if (!out_stall) begin
          cmd.rd_shift = 1'b1;
          if (status.lane_last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear_window, cmd.add_base, cmd.clear_sums,
              cmd.load_k, cmd.issue, cmd.rd_shift}))
    else $error("conflicting datapath commands");

  a_read_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && status.lane_last) |=> (state_r == ST_IDLE))
    else $error("readout did not end on the last lane");

  a_issue_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> !status.hash_empty)
    else $error("issue with an empty length range");

endmodule

`default_nettype wire

// File: hdl/kmer_soft_hash_accumulator.sv
// Top level of the k-mer soft hash accumulator.
//
// Input channel (in_valid/in_stall/in_data) takes one op per beat: start a
// string, add a DNA character, clear the sums or read all sums. A beat is
// taken when in_valid is high and in_stall is low; one item is worked on at
// a time and in_stall stays high until it is finished.
// An add-character item hashes n = hi - lo + 1 k-mer lengths, one per cycle
// into a five-stage fmix64 unit (three 32x32 partial products per multiply);
// in_stall stays high through setup, issue and drain, and with no length to
// hash the item ends after setup. Start and clear do not raise in_stall.
// A read item streams DIM beats on out_valid/out_stall/out_data from the
// cycle after it is taken, lane 0 first, last set on lane DIM-1; the sums
// rotate one place per beat, so a stall on out_stall simply holds the beat.
// The configuration port (cfg_valid/cfg_ready) is always ready and sets the
// shortest and longest k-mer lengths; write it only while the block is idle.
// Synchronous reset clears the base window, the sums and the lengths to
// their defaults; there is no clearing pass.
`default_nettype none

module kmer_soft_hash_accumulator
  import ksha_pkg::*;
#(
  parameter int DIM      = 64,
  parameter int MAX_KMER = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LEN_W-1:0]     cfg_data
);

  ksha_cmd_t    cmd;
  ksha_status_t status;

  assign cfg_ready = 1'b1;

  ksha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ksha_datapath #(
    .DIM      (DIM),
    .MAX_KMER (MAX_KMER)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
